>>> rtl/qts_pkg.sv
// ----------------------------------------------------------------------------
// qts_pkg
// Shared constants, types and the coefficient job table of the quintic
// trajectory sampler.
// ----------------------------------------------------------------------------
package qts_pkg;

   localparam int FRAC_BITS = 16;
   localparam int NW        = 288;
   localparam int NLIMB     = NW / 32;
   localparam int CW        = 200 + 2 * FRAC_BITS;
   localparam int QW        = 40;
   localparam int HSTEPS    = 5;
   localparam int NCOEF     = 6;
   localparam int DIV_BITS  = 32;
   localparam int NJOB      = 16;
   localparam int LATENCY   = 2 * HSTEPS + DIV_BITS + 4;

   localparam logic [31:0] DURATION_RESET = 32'd65536;
   localparam logic [31:0] POS_LIM        = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_LIM        = 32'h8000_0000;

   localparam logic [2:0] REG_START_POSITION = 3'd0;
   localparam logic [2:0] REG_START_VELOCITY = 3'd1;
   localparam logic [2:0] REG_START_ACCEL    = 3'd2;
   localparam logic [2:0] REG_END_POSITION   = 3'd3;
   localparam logic [2:0] REG_END_VELOCITY   = 3'd4;
   localparam logic [2:0] REG_END_ACCEL      = 3'd5;
   localparam logic [2:0] REG_DURATION       = 3'd6;

   typedef logic [NW-1:0] wide_type;
   typedef logic [NCOEF-1:0][NW-1:0] coef_set_type;

   typedef struct packed {
      logic signed [31:0] start_position;
      logic signed [31:0] start_velocity;
      logic signed [31:0] start_accel;
      logic signed [31:0] end_position;
      logic signed [31:0] end_velocity;
      logic signed [31:0] end_accel;
      logic [31:0]        segment_duration;
   } cfg_type;

   typedef struct packed {
      coef_set_type pos;
      coef_set_type vel;
      coef_set_type acc;
      wide_type     den;
      wide_type     den2;
   } poly_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] value;
      logic        sat;
   } lane_out_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_CLEAR,
      SQ_LOAD,
      SQ_STEP,
      SQ_STORE,
      SQ_FINISH
   } seq_state_type;

   typedef enum logic [3:0] {
      Q_DUR,
      Q_2P0,
      Q_2V0,
      Q_A0,
      Q_N20E,
      Q_NV3,
      Q_NA3,
      Q_30E,
      Q_V4,
      Q_A4,
      Q_N12E,
      Q_NV5,
      Q_NA5
   } q_sel_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_ONE,
      SH_TWO
   } shift_type;

   typedef struct packed {
      logic [2:0] src;
      q_sel_type  qs;
      shift_type  sh;
      logic       to_pw;
      logic [2:0] dst;
   } job_type;

   function automatic job_type job_entry(input logic [3:0] j);
      job_type r;
      unique case (j)
         4'd0:    r = '{3'd1, Q_DUR,  SH_NONE, 1'b1, 3'd2};
         4'd1:    r = '{3'd2, Q_DUR,  SH_NONE, 1'b1, 3'd3};
         4'd2:    r = '{3'd3, Q_DUR,  SH_NONE, 1'b1, 3'd4};
         4'd3:    r = '{3'd4, Q_DUR,  SH_NONE, 1'b1, 3'd5};
         4'd4:    r = '{3'd5, Q_2P0,  SH_TWO,  1'b0, 3'd0};
         4'd5:    r = '{3'd5, Q_2V0,  SH_ONE,  1'b0, 3'd1};
         4'd6:    r = '{3'd5, Q_A0,   SH_NONE, 1'b0, 3'd2};
         4'd7:    r = '{3'd2, Q_N20E, SH_TWO,  1'b0, 3'd3};
         4'd8:    r = '{3'd3, Q_NV3,  SH_ONE,  1'b0, 3'd3};
         4'd9:    r = '{3'd4, Q_NA3,  SH_NONE, 1'b0, 3'd3};
         4'd10:   r = '{3'd1, Q_30E,  SH_TWO,  1'b0, 3'd4};
         4'd11:   r = '{3'd2, Q_V4,   SH_ONE,  1'b0, 3'd4};
         4'd12:   r = '{3'd3, Q_A4,   SH_NONE, 1'b0, 3'd4};
         4'd13:   r = '{3'd0, Q_N12E, SH_TWO,  1'b0, 3'd5};
         4'd14:   r = '{3'd1, Q_NV5,  SH_ONE,  1'b0, 3'd5};
         default: r = '{3'd2, Q_NA5,  SH_NONE, 1'b0, 3'd5};
      endcase
      return r;
   endfunction

   function automatic wide_type sext_c(input logic [CW-1:0] x);
      return {{(NW - CW){x[CW-1]}}, x};
   endfunction

endpackage

>>> rtl/quintic_trajectory_sampler.sv
// ----------------------------------------------------------------------------
// quintic_trajectory_sampler
// Quintic trajectory set-point generator: position, velocity and
// acceleration at each sample time, saturated to signed Q16.16.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   req_sample_time                start & !busy
//  response  rsp_position .. rsp_bad_duration  rsp_valid, one cycle
//  config    csr_index, csr_data            csr_write
//
//  One item per cycle while busy is low; each result passes through the
//  five Horner steps (two stages each) and the 33-stage divider.
//  After reset and after every register write, busy stays high while
//  the coefficient sequencer (one multiplier bit per cycle) runs.
//  Reset is synchronous; the response side cannot stall.
// ----------------------------------------------------------------------------
module quintic_trajectory_sampler import qts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_sample_time,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_position,
   output logic signed [31:0] rsp_velocity,
   output logic signed [31:0] rsp_accel,
   output logic               rsp_saturated,
   output logic               rsp_bad_duration,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   cfg_type      cfg_ff;
   poly_type     poly;
   lane_out_type r_pos, r_vel, r_acc;
   logic         accept, bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_type'({192'd0, DURATION_RESET});
      end else if (csr_write) begin
         unique case (csr_index)
            REG_START_POSITION: cfg_ff.start_position   <= signed'(csr_data);
            REG_START_VELOCITY: cfg_ff.start_velocity   <= signed'(csr_data);
            REG_START_ACCEL:    cfg_ff.start_accel      <= signed'(csr_data);
            REG_END_POSITION:   cfg_ff.end_position     <= signed'(csr_data);
            REG_END_VELOCITY:   cfg_ff.end_velocity     <= signed'(csr_data);
            REG_END_ACCEL:      cfg_ff.end_accel        <= signed'(csr_data);
            REG_DURATION:       cfg_ff.segment_duration <= csr_data;
            default: begin
            end
         endcase
      end
   end

   qts_coef u_coef (
      .clock (clock),
      .reset (reset),
      .kick  (csr_write),
      .cfg   (cfg_ff),
      .busy  (busy),
      .poly  (poly)
   );

   assign accept = start && !busy;

   qts_lane u_pos (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_time  (req_sample_time),
      .coef     (poly.pos),
      .den      (poly.den),
      .den2     (poly.den2),
      .result   (r_pos)
   );

   qts_lane u_vel (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_time  (req_sample_time),
      .coef     (poly.vel),
      .den      (poly.den),
      .den2     (poly.den2),
      .result   (r_vel)
   );

   qts_lane u_acc (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_time  (req_sample_time),
      .coef     (poly.acc),
      .den      (poly.den),
      .den2     (poly.den2),
      .result   (r_acc)
   );

   assign bad              = cfg_ff.segment_duration == 32'd0;
   assign rsp_valid        = r_pos.valid & r_vel.valid & r_acc.valid;
   assign rsp_position     = bad ? 32'sd0 : signed'(r_pos.value);
   assign rsp_velocity     = bad ? 32'sd0 : signed'(r_vel.value);
   assign rsp_accel        = bad ? 32'sd0 : signed'(r_acc.value);
   assign rsp_saturated    = !bad && (r_pos.sat || r_vel.sat || r_acc.sat);
   assign rsp_bad_duration = bad;

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> busy)
      else $error("register write did not start coefficient reload");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted item produced no result in time");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      r_pos.valid == r_vel.valid && r_pos.valid == r_acc.valid)
      else $error("lane valid bits out of step");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_duration |->
         rsp_position == 32'sd0 && rsp_accel == 32'sd0 && !rsp_saturated)
      else $error("zero duration result not cleared");

endmodule

>>> rtl/qts_coef.sv
// ----------------------------------------------------------------------------
// qts_coef
// Bit-serial sequencer that turns the configuration into the polynomial
// coefficients and the rounding divisor of all three lanes.
// ----------------------------------------------------------------------------
module qts_coef import qts_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     kick,
   input  cfg_type  cfg,
   output logic     busy,
   output poly_type poly
);

   localparam int BW = $clog2(QW);
   localparam logic [BW-1:0] BIT_LAST = BW'(QW - 1);
   localparam logic [3:0]    JOB_LAST = 4'(NJOB - 1);

   seq_state_type   state_ff, state_in;
   logic [3:0]      job_ff;
   logic [BW-1:0]   bit_ff;
   logic [CW-1:0]   acc_ff, mx_ff;
   logic [QW-1:0]   qy_ff;
   logic [CW-1:0]   pw_ff [2:5];
   logic [CW-1:0]   c_ff [0:5];
   poly_type        poly_ff;

   job_type         job;
   logic            last_bit;
   logic [CW-1:0]   src_val, src_sh;
   logic signed [QW-1:0] p0, v0, a0, p1, v1, a1, e, q_val;
   wide_type        pc [0:5];
   poly_type        poly_in;

   assign job      = job_entry(job_ff);
   assign last_bit = bit_ff == BIT_LAST;

   always_comb begin
      unique case (state_ff)
         SQ_IDLE:   state_in = SQ_IDLE;
         SQ_CLEAR:  state_in = SQ_LOAD;
         SQ_LOAD:   state_in = SQ_STEP;
         SQ_STEP:   state_in = last_bit ? SQ_STORE : SQ_STEP;
         SQ_STORE:  state_in = (job_ff == JOB_LAST) ? SQ_FINISH : SQ_LOAD;
         SQ_FINISH: state_in = SQ_IDLE;
         default:   state_in = SQ_IDLE;
      endcase
      if (kick) begin
         state_in = SQ_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      p0 = QW'(cfg.start_position);
      v0 = QW'(cfg.start_velocity);
      a0 = QW'(cfg.start_accel);
      p1 = QW'(cfg.end_position);
      v1 = QW'(cfg.end_velocity);
      a1 = QW'(cfg.end_accel);
      e  = p0 - p1;
      unique case (job.qs)
         Q_DUR:   q_val = signed'(QW'(cfg.segment_duration));
         Q_2P0:   q_val = p0 <<< 1;
         Q_2V0:   q_val = v0 <<< 1;
         Q_A0:    q_val = a0;
         Q_N20E:  q_val = -((e <<< 4) + (e <<< 2));
         Q_NV3:   q_val = -((v0 <<< 3) + (v0 <<< 2) + (v1 <<< 3));
         Q_NA3:   q_val = -((a0 <<< 1) + a0 - a1);
         Q_30E:   q_val = (e <<< 5) - (e <<< 1);
         Q_V4:    q_val = (v0 <<< 4) + (v1 <<< 4) - (v1 <<< 1);
         Q_A4:    q_val = (a0 <<< 1) + a0 - (a1 <<< 1);
         Q_N12E:  q_val = -((e <<< 3) + (e <<< 2));
         Q_NV5:   q_val = -(((v0 + v1) <<< 2) + ((v0 + v1) <<< 1));
         Q_NA5:   q_val = a1 - a0;
         default: q_val = '0;
      endcase
   end

   always_comb begin
      unique case (job.src)
         3'd0:    src_val = CW'(1);
         3'd1:    src_val = CW'(cfg.segment_duration);
         default: src_val = pw_ff[job.src];
      endcase
      unique case (job.sh)
         SH_NONE: src_sh = src_val;
         SH_ONE:  src_sh = src_val << FRAC_BITS;
         SH_TWO:  src_sh = src_val << (2 * FRAC_BITS);
         default: src_sh = src_val;
      endcase
   end

   always_comb begin
      for (int j = 0; j < NCOEF; j++) begin
         pc[j] = sext_c(c_ff[j]);
         poly_in.pos[j] = pc[j];
      end
      poly_in.vel[0] = pc[1] << FRAC_BITS;
      poly_in.vel[1] = pc[2] << (FRAC_BITS + 1);
      poly_in.vel[2] = (pc[3] + (pc[3] << 1)) << FRAC_BITS;
      poly_in.vel[3] = pc[4] << (FRAC_BITS + 2);
      poly_in.vel[4] = (pc[5] + (pc[5] << 2)) << FRAC_BITS;
      poly_in.vel[5] = '0;
      poly_in.acc[0] = pc[2] << (2 * FRAC_BITS + 1);
      poly_in.acc[1] = ((pc[3] << 1) + (pc[3] << 2)) << (2 * FRAC_BITS);
      poly_in.acc[2] = ((pc[4] << 2) + (pc[4] << 3)) << (2 * FRAC_BITS);
      poly_in.acc[3] = ((pc[5] << 2) + (pc[5] << 4)) << (2 * FRAC_BITS);
      poly_in.acc[4] = '0;
      poly_in.acc[5] = '0;
      poly_in.den    = NW'(pw_ff[5]) << (2 * FRAC_BITS + 1);
      poly_in.den2   = NW'(pw_ff[5]) << (2 * FRAC_BITS + 2);
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         SQ_CLEAR: begin
            job_ff <= '0;
            for (int j = 0; j < NCOEF; j++) begin
               c_ff[j] <= '0;
            end
         end
         SQ_LOAD: begin
            acc_ff <= job.to_pw ? '0 : c_ff[job.dst];
            mx_ff  <= src_sh;
            qy_ff  <= q_val;
            bit_ff <= '0;
         end
         SQ_STEP: begin
            if (qy_ff[0]) begin
               acc_ff <= last_bit ? acc_ff - mx_ff : acc_ff + mx_ff;
            end
            mx_ff  <= mx_ff << 1;
            qy_ff  <= qy_ff >> 1;
            bit_ff <= bit_ff + BW'(1);
         end
         SQ_STORE: begin
            if (job.to_pw) begin
               pw_ff[job.dst] <= acc_ff;
            end else begin
               c_ff[job.dst] <= acc_ff;
            end
            job_ff <= job_ff + 4'd1;
         end
         SQ_FINISH: begin
            poly_ff <= poly_in;
         end
         default: begin
         end
      endcase
   end

   assign busy = state_ff != SQ_IDLE;
   assign poly = poly_ff;

endmodule

>>> rtl/qts_lane.sv
// ----------------------------------------------------------------------------
// qts_lane
// One output lane: Horner evaluation in time, round-to-nearest division by
// the common divisor and saturation to 32 bits.
// ----------------------------------------------------------------------------
module qts_lane import qts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [31:0]  in_time,
   input  coef_set_type coef,
   input  wide_type     den,
   input  wide_type     den2,
   output lane_out_type result
);

   logic        v_ff  [0:HSTEPS];
   logic [31:0] t_ff  [0:HSTEPS-1];
   wide_type    h_ff  [1:HSTEPS];
   logic [63:0] pp_ff [0:HSTEPS-1][0:NLIMB-1];
   logic        av_ff [0:HSTEPS-1];
   logic [31:0] at_ff [0:HSTEPS-1];

   wide_type    rem_ff [0:DIV_BITS];
   logic [31:0] q_ff   [1:DIV_BITS+1];
   logic        ovf_ff [1:DIV_BITS+1];
   logic        sg_ff  [0:DIV_BITS+1];
   logic        dv_ff  [0:DIV_BITS+1];
   lane_out_type out_ff;

   wide_type    dbl;
   logic        neg_h;
   logic [31:0] lim, m_val, q_fin;
   logic        sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      t_ff[0] <= in_time;
   end

   for (genvar s = 0; s < HSTEPS; s++) begin : g_horner
      wide_type hsrc;
      logic [NW+63:0] ev, od;

      if (s == 0) begin : g_first
         assign hsrc = coef[NCOEF-1];
      end else begin : g_next
         assign hsrc = h_ff[s];
      end

      always_ff @(posedge clock) begin
         for (int j = 0; j < NLIMB; j++) begin
            pp_ff[s][j] <= 64'(hsrc[32*j +: 32]) * 64'(t_ff[s]);
         end
         at_ff[s] <= t_ff[s];
         if (reset) begin
            av_ff[s] <= 1'b0;
         end else begin
            av_ff[s] <= v_ff[s];
         end
      end

      always_comb begin
         ev = '0;
         od = '0;
         for (int j = 0; j < NLIMB; j++) begin
            if (j % 2 == 0) begin
               ev[32*j +: 64] = pp_ff[s][j];
            end else begin
               od[32*j +: 64] = pp_ff[s][j];
            end
         end
      end

      always_ff @(posedge clock) begin
         h_ff[s+1] <= ev[NW-1:0] + od[NW-1:0] + coef[NCOEF-2-s];
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else begin
            v_ff[s+1] <= av_ff[s];
         end
      end

      if (s < HSTEPS - 1) begin : g_time
         always_ff @(posedge clock) begin
            t_ff[s+1] <= at_ff[s];
         end
      end
   end

   assign neg_h = h_ff[HSTEPS][NW-1];
   assign dbl   = h_ff[HSTEPS] << 1;

   always_ff @(posedge clock) begin
      rem_ff[0] <= neg_h ? den - dbl : dbl + den;
      sg_ff[0]  <= neg_h;
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= v_ff[HSTEPS];
      end
   end

   for (genvar d = 0; d <= DIV_BITS; d++) begin : g_div
      wide_type divisor;
      logic     ge;

      assign divisor = den2 << (DIV_BITS - d);
      assign ge      = rem_ff[d] >= divisor;

      always_ff @(posedge clock) begin
         sg_ff[d+1] <= sg_ff[d];
         if (reset) begin
            dv_ff[d+1] <= 1'b0;
         end else begin
            dv_ff[d+1] <= dv_ff[d];
         end
      end

      if (d == 0) begin : g_over
         always_ff @(posedge clock) begin
            rem_ff[1] <= rem_ff[0];
            ovf_ff[1] <= ge;
            q_ff[1]   <= '0;
         end
      end else begin : g_bit
         always_ff @(posedge clock) begin
            q_ff[d+1]   <= q_ff[d] | (32'(ge) << (DIV_BITS - d));
            ovf_ff[d+1] <= ovf_ff[d];
         end
         if (d < DIV_BITS) begin : g_rem
            always_ff @(posedge clock) begin
               rem_ff[d+1] <= ge ? rem_ff[d] - divisor : rem_ff[d];
            end
         end
      end
   end

   always_comb begin
      q_fin = q_ff[DIV_BITS+1];
      lim   = sg_ff[DIV_BITS+1] ? NEG_LIM : POS_LIM;
      sat   = ovf_ff[DIV_BITS+1] || (q_fin > lim);
      m_val = sat ? lim : q_fin;
   end

   always_ff @(posedge clock) begin
      out_ff.value <= sg_ff[DIV_BITS+1] ? 32'd0 - m_val : m_val;
      out_ff.sat   <= sat;
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= dv_ff[DIV_BITS+1];
      end
   end

   assign result = out_ff;

endmodule

>>> test/trajectory_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trajectory_checker
// Watches the sample, result and register channels of the quintic trajectory
// sampler, works out position, velocity and acceleration exactly in wide
// integers with round-half-away and saturation, and compares every result.
// ----------------------------------------------------------------------------
module trajectory_checker import qts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [31:0]        req_sample_time,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_position,
   input  logic signed [31:0] rsp_velocity,
   input  logic signed [31:0] rsp_accel,
   input  logic               rsp_saturated,
   input  logic               rsp_bad_duration,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 pending,
   output int                 checked_count,
   output int                 sat_count
);

   typedef logic signed [383:0] wint_type;

   typedef struct {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] accel;
      logic               saturated;
      logic               bad_duration;
   } set_point_type;

   cfg_type       segment;
   set_point_type set_points[$];

   function automatic logic [31:0] round_clip(input wint_type num, input wint_type den,
                                              inout logic sat);
      wint_type mag, q, lim;
      logic  neg;
      neg = num < 0;
      mag = neg ? -num : num;
      q   = (2 * mag + den) / (2 * den);
      lim = neg ? wint_type'(64'h8000_0000) : wint_type'(64'h7FFF_FFFF);
      if (q > lim) begin
         sat = 1'b1;
         q   = lim;
      end
      if (neg) q = -q;
      return q[31:0];
   endfunction

   function automatic set_point_type sample_segment(input cfg_type c,
                                                    input logic [31:0] t);
      wint_type p0, v0, a0, p1, v1, a1, dp, dd, tt, s1, s2, d2, d5;
      wint_type t2, t3, t4, t5, m3, m4, m5, num, den;
      logic sat;
      set_point_type r;
      sat = 1'b0;
      if (c.segment_duration == 32'd0) begin
         r = '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b1};
         return r;
      end
      p0 = c.start_position;
      v0 = c.start_velocity;
      a0 = c.start_accel;
      p1 = c.end_position;
      v1 = c.end_velocity;
      a1 = c.end_accel;
      dd = c.segment_duration;
      tt = t;
      dp = p0 - p1;
      s1 = 1;
      s1 = s1 << FRAC_BITS;
      s2 = s1 * s1;
      d2 = dd * dd;
      d5 = d2 * d2 * dd;
      t2 = tt * tt;
      t3 = t2 * tt;
      t4 = t3 * tt;
      t5 = t4 * tt;
      m3 = 20 * dp * s2 + (12 * v0 + 8 * v1) * dd * s1 + (3 * a0 - a1) * d2;
      m4 = 30 * dp * s2 + (16 * v0 + 14 * v1) * dd * s1 + (3 * a0 - 2 * a1) * d2;
      m5 = 12 * dp * s2 + 6 * (v0 + v1) * dd * s1 + (a0 - a1) * d2;

      num = 2 * p0 * d5 * s2 + 2 * v0 * d5 * s1 * tt + a0 * d5 * t2
            - d2 * m3 * t3 + dd * m4 * t4 - m5 * t5;
      den = 2 * d5 * s2;
      r.position = round_clip(num, den, sat);

      num = 2 * v0 * d5 * s1 + 2 * a0 * d5 * tt - 3 * d2 * m3 * t2
            + 4 * dd * m4 * t3 - 5 * m5 * t4;
      den = 2 * d5 * s1;
      r.velocity = round_clip(num, den, sat);

      num = 2 * a0 * d5 - 6 * d2 * m3 * tt + 12 * dd * m4 * t2 - 20 * m5 * t3;
      den = 2 * d5;
      r.accel = round_clip(num, den, sat);

      r.saturated    = sat;
      r.bad_duration = 1'b0;
      return r;
   endfunction

   assign pending = set_points.size();

   always @(posedge clock) begin
      set_point_type exp_sp;
      if (reset) begin
         segment <= cfg_type'({192'd0, DURATION_RESET});
         set_points.delete();
         fail_count    <= 0;
         checked_count <= 0;
         sat_count     <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_START_POSITION: segment.start_position   <= csr_data;
               REG_START_VELOCITY: segment.start_velocity   <= csr_data;
               REG_START_ACCEL:    segment.start_accel      <= csr_data;
               REG_END_POSITION:   segment.end_position     <= csr_data;
               REG_END_VELOCITY:   segment.end_velocity     <= csr_data;
               REG_END_ACCEL:      segment.end_accel        <= csr_data;
               REG_DURATION:       segment.segment_duration <= csr_data;
               default: ;
            endcase
         end
         if (start && !busy) set_points.push_back(sample_segment(segment, req_sample_time));
         if (rsp_valid) begin
            checked_count <= checked_count + 1;
            if (rsp_saturated) sat_count <= sat_count + 1;
            if (set_points.size() == 0) begin
               if (fail_count < 10) $display("checker: result with no item pending");
               fail_count <= fail_count + 1;
            end else begin
               exp_sp = set_points.pop_front();
               if (rsp_position !== exp_sp.position || rsp_velocity !== exp_sp.velocity ||
                   rsp_accel !== exp_sp.accel || rsp_saturated !== exp_sp.saturated ||
                   rsp_bad_duration !== exp_sp.bad_duration) begin
                  if (fail_count < 10)
                     $display({"checker: mismatch exp p=%h v=%h a=%h s=%b b=%b ",
                               "got p=%h v=%h a=%h s=%b b=%b"},
                              exp_sp.position, exp_sp.velocity, exp_sp.accel,
                              exp_sp.saturated, exp_sp.bad_duration, rsp_position,
                              rsp_velocity, rsp_accel, rsp_saturated, rsp_bad_duration);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sample times into the quintic trajectory sampler over a series of
// segment settings and idle patterns; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top import qts_pkg::*; ();

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [31:0]        req_sample_time;
   logic               rsp_valid;
   logic signed [31:0] rsp_position;
   logic signed [31:0] rsp_velocity;
   logic signed [31:0] rsp_accel;
   logic               rsp_saturated;
   logic               rsp_bad_duration;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;
   int                 fail_count, pending, checked_count, sat_count;
   int                 quiet_cycles;
   int                 idle_pct;
   logic [31:0]        dur;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quintic_trajectory_sampler DUT (.*);

   trajectory_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic send_sample(input logic [31:0] t);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_sample_time <= t;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
   endtask

   task automatic set_segment(input logic [31:0] p0, v0, a0, p1, v1, a1, d);
      drain();
      write_reg(REG_START_POSITION, p0);
      write_reg(REG_START_VELOCITY, v0);
      write_reg(REG_START_ACCEL, a0);
      write_reg(REG_END_POSITION, p1);
      write_reg(REG_END_VELOCITY, v1);
      write_reg(REG_END_ACCEL, a1);
      write_reg(REG_DURATION, d);
      csr_write <= 1'b0;
   endtask

   function automatic logic [31:0] small_signed();
      logic [31:0] v;
      v = $urandom_range(32'h0080_0000);
      return $urandom_range(1) ? -v : v;
   endfunction

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_sample_time = '0;
      csr_write       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      idle_pct        = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // defaults: all zero, one second
      send_sample(32'd0);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h0001_0000);
      send_sample(32'h0000_8000);
      // realistic move
      set_segment(32'h0001_0000, 32'h0000_4000, 32'hFFFF_C000, 32'h0010_0000,
                  32'hFFFF_0000, 32'h0000_2000, 32'h0002_0000);
      send_sample(32'd0);
      send_sample(32'h0001_0000);
      send_sample(32'h0002_0000);
      send_sample(32'h0003_0000);
      send_sample(32'hFFFF_FFFF);
      // zero duration
      set_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_sample(32'd0);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h5555_AAAA);
      // extremes, shortest duration
      set_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'd1);
      send_sample(32'd0);
      send_sample(32'd1);
      send_sample(32'hFFFF_FFFF);
      // extremes, longest duration
      set_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_sample(32'd0);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h0000_0001);

      for (int ph = 0; ph < 20; ph++) begin
         case (ph % 4)
            0: idle_pct = 0;
            1: idle_pct = 72;
            2: idle_pct = 37;
            default: idle_pct = 0;
         endcase
         if (ph % 5 == 4) begin
            dur = $urandom();
            set_segment($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), dur);
         end else begin
            dur = $urandom_range(32'h0010_0000, 32'h0000_4000);
            set_segment(small_signed(), small_signed(), small_signed(), small_signed(),
                        small_signed(), small_signed(), dur);
         end
         for (int k = 0; k < 95; k++) begin
            if ($urandom_range(9) < 8) send_sample($urandom_range(dur, 0));
            else send_sample($urandom());
         end
      end

      drain();
      $display("tb_top: %0d results checked over 24 segment settings, %0d saturated",
               checked_count, sat_count);
      if (fail_count == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

endmodule
